@@ hdl/ttot_pkg.sv @@
// Shared constants for the triangle pair overlap pipeline.
`default_nettype none
package ttot_pkg;
  localparam int COORD_WIDTH = 16;
  localparam int SLOT_W      = 16;
  localparam int VERTEX_W    = 3 * SLOT_W;
  localparam int TOL_W       = 20;
  localparam int NUM_VERT    = 3;
  localparam int NUM_AXES    = 3;
  localparam int NUM_STAGES  = 6;
endpackage
`default_nettype wire

@@ hdl/ttot_if.sv @@
// Handshake channels for triangle pairs, overlap results and the tolerance register.
`default_nettype none
interface ttot_in_if;
  logic                          valid;
  logic                          ready;
  logic [ttot_pkg::VERTEX_W-1:0] a_vertex0;
  logic [ttot_pkg::VERTEX_W-1:0] a_vertex1;
  logic [ttot_pkg::VERTEX_W-1:0] a_vertex2;
  logic [ttot_pkg::VERTEX_W-1:0] b_vertex0;
  logic [ttot_pkg::VERTEX_W-1:0] b_vertex1;
  logic [ttot_pkg::VERTEX_W-1:0] b_vertex2;
  modport source (output valid, a_vertex0, a_vertex1, a_vertex2,
                  b_vertex0, b_vertex1, b_vertex2, input ready);
  modport sink   (input valid, a_vertex0, a_vertex1, a_vertex2,
                  b_vertex0, b_vertex1, b_vertex2, output ready);
endinterface

interface ttot_out_if;
  logic valid;
  logic ready;
  logic overlap;
  logic plane_separated;
  modport source (output valid, overlap, plane_separated, input ready);
  modport sink   (input valid, overlap, plane_separated, output ready);
endinterface

interface ttot_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ttot_pkg::TOL_W-1:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink   (input valid, tolerance, output ready);
endinterface
`default_nettype wire

@@ hdl/ttot_cross.sv @@
// Two-stage cross product: registered partial products, then registered differences.
`default_nettype none
module ttot_cross #(
  parameter int DW = ttot_pkg::COORD_WIDTH + 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [DW-1:0]  a_i [ttot_pkg::NUM_AXES],
  input  logic signed [DW-1:0]  b_i [ttot_pkg::NUM_AXES],
  output logic signed [2*DW:0]  n_o [ttot_pkg::NUM_AXES]
);
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] prod_q [6];
  logic signed [NW-1:0] n_d [ttot_pkg::NUM_AXES];
  logic signed [NW-1:0] n_q [ttot_pkg::NUM_AXES];

  always_comb begin
    prod_d[0] = PW'(a_i[1]) * PW'(b_i[2]);
    prod_d[1] = PW'(a_i[2]) * PW'(b_i[1]);
    prod_d[2] = PW'(a_i[2]) * PW'(b_i[0]);
    prod_d[3] = PW'(a_i[0]) * PW'(b_i[2]);
    prod_d[4] = PW'(a_i[0]) * PW'(b_i[1]);
    prod_d[5] = PW'(a_i[1]) * PW'(b_i[0]);
    n_d[0] = NW'(prod_q[0]) - NW'(prod_q[1]);
    n_d[1] = NW'(prod_q[2]) - NW'(prod_q[3]);
    n_d[2] = NW'(prod_q[4]) - NW'(prod_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      n_q    <= n_d;
    end
  end

  assign n_o = n_q;
endmodule
`default_nettype wire

@@ hdl/ttot_dot.sv @@
// Two-stage dot product: registered products, then registered sum.
`default_nettype none
module ttot_dot #(
  parameter int AW = 2 * ttot_pkg::COORD_WIDTH + 3,
  parameter int BW = 2 * ttot_pkg::COORD_WIDTH + 3
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i [ttot_pkg::NUM_AXES],
  input  logic signed [BW-1:0]    b_i [ttot_pkg::NUM_AXES],
  output logic signed [AW+BW+1:0] sum_o
);
  localparam int PW = AW + BW;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_d [ttot_pkg::NUM_AXES];
  logic signed [PW-1:0] prod_q [ttot_pkg::NUM_AXES];
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] sum_q;

  always_comb begin
    for (int c = 0; c < ttot_pkg::NUM_AXES; c++) begin
      prod_d[c] = PW'(a_i[c]) * PW'(b_i[c]);
    end
    sum_d = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule
`default_nettype wire

@@ hdl/triangle_triangle_overlap_test.sv @@
// Top level of the triangle pair overlap pipeline.
`default_nettype none
// Takes one triangle pair per clock unless the output is stalled, and returns one
// result per pair, in order. The pipeline runs edge differences, cross-product
// multiply, cross-product subtract, dot multiply, dot sum and a final
// compare/reduce stage; when the result register is full and not taken,
// every stage holds together, so ready drops only while the output is stalled.
// plane_separated flags all vertices of A on one side of B's plane by at least
// the tolerance; overlap is then always 0. Tolerance is written through the
// configuration channel, which is always ready, and must only change while idle.
module triangle_triangle_overlap_test #(
  parameter int COORD_WIDTH = ttot_pkg::COORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttot_in_if.sink    in_i,
  ttot_out_if.source out_o,
  ttot_cfg_if.sink   cfg_i
);
  localparam int NA  = ttot_pkg::NUM_AXES;
  localparam int NV  = ttot_pkg::NUM_VERT;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int PSW = 2 * NW + 2;
  localparam int OSW = NW + DW + 2;
  localparam int NS  = ttot_pkg::NUM_STAGES;
  localparam int TW  = ttot_pkg::TOL_W;

  logic [TW-1:0] tol_q;
  logic [NS-1:0] vld_q;
  logic          en;
  logic          sep_d, sep_q, hit_d, hit_q;

  logic [ttot_pkg::VERTEX_W-1:0] vert [2][NV];
  logic signed [COORD_WIDTH-1:0] pt [2][NV][NA];

  // stage one: differences
  logic signed [DW-1:0] e0_q [2][NV][NA];
  logic signed [DW-1:0] e1_q [2][NV][NA];
  logic signed [DW-1:0] qp_q [2][NV][NV][NA];
  logic signed [DW-1:0] eb1_q [NA];
  logic signed [DW-1:0] eb2_q [NA];
  logic signed [DW-1:0] qa_q [NV][NA];
  logic signed [DW-1:0] qa2_q [NV][NA];
  logic signed [DW-1:0] qa3_q [NV][NA];

  logic signed [NW-1:0] n0 [2][NV][NA];
  logic signed [NW-1:0] n1 [2][NV][NV][NA];
  logic signed [NW-1:0] nb [NA];

  logic signed [PSW-1:0] psum [2][NV][NV];
  logic signed [OSW-1:0] osum [NV];

  assign en = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  assign vert[0][0] = in_i.a_vertex0;
  assign vert[0][1] = in_i.a_vertex1;
  assign vert[0][2] = in_i.a_vertex2;
  assign vert[1][0] = in_i.b_vertex0;
  assign vert[1][1] = in_i.b_vertex1;
  assign vert[1][2] = in_i.b_vertex2;

  for (genvar t = 0; t < 2; t++) begin : g_unpack_t
    for (genvar v = 0; v < NV; v++) begin : g_unpack_v
      for (genvar c = 0; c < NA; c++) begin : g_unpack_c
        assign pt[t][v][c] = $signed(vert[t][v][ttot_pkg::SLOT_W*c +: COORD_WIDTH]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // prism test differences and crosses, per triangle t and corner i
  for (genvar t = 0; t < 2; t++) begin : g_tri
    for (genvar i = 0; i < NV; i++) begin : g_corner
      localparam int J = (i + 1) % NV;
      localparam int K = (i + 2) % NV;
      for (genvar c = 0; c < NA; c++) begin : g_edge
        always_ff @(posedge clk_i) begin
          if (en) begin
            e0_q[t][i][c] <= DW'(pt[t][J][c]) - DW'(pt[t][i][c]);
            e1_q[t][i][c] <= DW'(pt[t][K][c]) - DW'(pt[t][i][c]);
          end
        end
      end
      ttot_cross #(.DW(DW)) u_n0 (
        .clk_i, .en_i(en), .a_i(e0_q[t][i]), .b_i(e1_q[t][i]), .n_o(n0[t][i])
      );
      for (genvar p = 0; p < NV; p++) begin : g_point
        for (genvar c = 0; c < NA; c++) begin : g_q
          always_ff @(posedge clk_i) begin
            if (en) begin
              qp_q[t][i][p][c] <= DW'(pt[1-t][p][c]) - DW'(pt[t][i][c]);
            end
          end
        end
        ttot_cross #(.DW(DW)) u_n1 (
          .clk_i, .en_i(en), .a_i(e0_q[t][i]), .b_i(qp_q[t][i][p]),
          .n_o(n1[t][i][p])
        );
        ttot_dot #(.AW(NW), .BW(NW)) u_pdot (
          .clk_i, .en_i(en), .a_i(n0[t][i]), .b_i(n1[t][i][p]),
          .sum_o(psum[t][i][p])
        );
      end
    end
  end

  // plane of B and orientation of each A vertex
  for (genvar c = 0; c < NA; c++) begin : g_plane
    always_ff @(posedge clk_i) begin
      if (en) begin
        eb1_q[c] <= DW'(pt[1][1][c]) - DW'(pt[1][0][c]);
        eb2_q[c] <= DW'(pt[1][0][c]) - DW'(pt[1][2][c]);
      end
    end
  end

  ttot_cross #(.DW(DW)) u_nb (
    .clk_i, .en_i(en), .a_i(eb1_q), .b_i(eb2_q), .n_o(nb)
  );

  for (genvar k = 0; k < NV; k++) begin : g_ori
    for (genvar c = 0; c < NA; c++) begin : g_oq
      // hold the vertex offsets until the normal is ready
      always_ff @(posedge clk_i) begin
        if (en) begin
          qa_q[k][c]  <= DW'(pt[0][k][c]) - DW'(pt[1][0][c]);
          qa2_q[k][c] <= qa_q[k][c];
          qa3_q[k][c] <= qa2_q[k][c];
        end
      end
    end
    ttot_dot #(.AW(NW), .BW(DW)) u_odot (
      .clk_i, .en_i(en), .a_i(nb), .b_i(qa3_q[k]), .sum_o(osum[k])
    );
  end

  // final compare and reduce
  always_comb begin
    logic signed [PSW:0] tol_p;
    logic signed [OSW:0] tol_o, v, mag;
    logic                all_big, pos_any, neg_any, any_pt, pt_ok;
    tol_p   = $signed({{(PSW+1-TW){1'b0}}, tol_q});
    tol_o   = $signed({{(OSW+1-TW){1'b0}}, tol_q});
    all_big = 1'b1;
    pos_any = 1'b0;
    neg_any = 1'b0;
    for (int k = 0; k < NV; k++) begin
      v   = (OSW+1)'(osum[k]);
      mag = v[OSW] ? -v : v;
      if (mag < tol_o) all_big = 1'b0;
      if (v[OSW]) neg_any = 1'b1;
      else        pos_any = 1'b1;
    end
    sep_d  = all_big && !(pos_any && neg_any);
    any_pt = 1'b0;
    for (int t = 0; t < 2; t++) begin
      for (int p = 0; p < NV; p++) begin
        pt_ok = 1'b1;
        for (int i = 0; i < NV; i++) begin
          if ((PSW+1)'(psum[t][i][p]) + tol_p <= 0) pt_ok = 1'b0;
        end
        if (pt_ok) any_pt = 1'b1;
      end
    end
    hit_d = any_pt && !sep_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sep_q <= sep_d;
      hit_q <= hit_d;
    end
  end

  assign out_o.valid           = vld_q[NS-1];
  assign out_o.overlap         = hit_q;
  assign out_o.plane_separated = sep_q;

  a_sep_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.overlap && out_o.plane_separated))
    else $error("overlap flagged on a separated pair");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline advanced during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted request not tracked in first stage");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |=> tol_q == $past(cfg_i.tolerance))
    else $error("tolerance write lost");
endmodule
`default_nettype wire

@@ sim/triangle_overlap_checker.sv @@
// Checker for the triangle pair overlap block: watches the channels, predicts and compares.
`timescale 1ns / 1ps
`default_nettype none
module triangle_overlap_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ttot_in_if.sink     pair_if,
  ttot_out_if.sink    res_if,
  ttot_cfg_if.sink    cfg_if,
  output int          fail_count,
  output int          expected_left,
  output int          results_seen,
  output int          overlap_seen,
  output int          separated_seen
);
  typedef struct packed {
    logic overlap;
    logic plane_separated;
  } verdict_t;

  typedef logic signed [63:0] coord3_t [3];

  verdict_t                       verdict_q[$];
  logic [ttot_pkg::TOL_W-1:0]     tol_shadow;

  function automatic coord3_t unpack_point(logic [ttot_pkg::VERTEX_W-1:0] word);
    coord3_t p;
    logic [ttot_pkg::SLOT_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = word[k*ttot_pkg::SLOT_W +: ttot_pkg::SLOT_W];
      p[k] = 64'(signed'(s[ttot_pkg::COORD_WIDTH-1:0]));
    end
    return p;
  endfunction

  function automatic coord3_t diff3(coord3_t a, coord3_t b);
    coord3_t r;
    for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
    return r;
  endfunction

  function automatic coord3_t cross_of(coord3_t a, coord3_t b);
    coord3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic inside_prism(coord3_t t0, coord3_t t1, coord3_t t2,
                                        coord3_t p, logic [ttot_pkg::TOL_W-1:0] tol);
    coord3_t tri_pts [3];
    coord3_t n0, n1;
    logic signed [127:0] acc;
    int j, k;
    tri_pts[0] = t0; tri_pts[1] = t1; tri_pts[2] = t2;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      n0 = cross_of(diff3(tri_pts[j], tri_pts[i]), diff3(tri_pts[k], tri_pts[i]));
      n1 = cross_of(diff3(tri_pts[j], tri_pts[i]), diff3(p, tri_pts[i]));
      acc = 128'(tol);
      for (int c = 0; c < 3; c++)
        acc += 128'(n0[c]) * 128'(n1[c]);
      if (acc <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t judge_pair(logic [ttot_pkg::VERTEX_W-1:0] w [6],
                                          logic [ttot_pkg::TOL_W-1:0] tol);
    coord3_t ta [3];
    coord3_t tb [3];
    coord3_t nb, d;
    logic signed [63:0] ori [3];
    logic [63:0] mag;
    logic all_big, same;
    verdict_t v;
    all_big = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ta[k] = unpack_point(w[k]);
      tb[k] = unpack_point(w[3+k]);
    end
    nb = cross_of(diff3(tb[1], tb[0]), diff3(tb[0], tb[2]));
    for (int k = 0; k < 3; k++) begin
      d = diff3(ta[k], tb[0]);
      ori[k] = nb[0] * d[0] + nb[1] * d[1] + nb[2] * d[2];
      mag = ori[k] < 0 ? -ori[k] : ori[k];
      if (mag < 64'(tol)) all_big = 1'b0;
    end
    same = ((ori[0] < 0) == (ori[1] < 0)) && ((ori[0] < 0) == (ori[2] < 0));
    v.plane_separated = all_big && same;
    v.overlap = 1'b0;
    if (!v.plane_separated) begin
      for (int k = 0; k < 3; k++)
        if (inside_prism(ta[0], ta[1], ta[2], tb[k], tol)) v.overlap = 1'b1;
      for (int k = 0; k < 3; k++)
        if (inside_prism(tb[0], tb[1], tb[2], ta[k], tol)) v.overlap = 1'b1;
    end
    return v;
  endfunction

  assign expected_left = verdict_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ttot_pkg::VERTEX_W-1:0] w [6];
    verdict_t want;
    if (!rst_ni) begin
      tol_shadow     <= '0;
      fail_count     <= 0;
      results_seen   <= 0;
      overlap_seen   <= 0;
      separated_seen <= 0;
      verdict_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) tol_shadow <= cfg_if.tolerance;
      if (pair_if.valid && pair_if.ready) begin
        w[0] = pair_if.a_vertex0; w[1] = pair_if.a_vertex1; w[2] = pair_if.a_vertex2;
        w[3] = pair_if.b_vertex0; w[4] = pair_if.b_vertex1; w[5] = pair_if.b_vertex2;
        verdict_q.push_back(judge_pair(w, tol_shadow));
      end
      if (res_if.valid && res_if.ready) begin
        results_seen <= results_seen + 1;
        overlap_seen <= overlap_seen + res_if.overlap;
        separated_seen <= separated_seen + res_if.plane_separated;
        if (verdict_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing outstanding (overlap=%b sep=%b)",
                     $realtime, res_if.overlap, res_if.plane_separated);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want.overlap !== res_if.overlap ||
              want.plane_separated !== res_if.plane_separated) begin
            if (fail_count < 10)
              $display("%0t: mismatch overlap exp %b got %b, plane_separated exp %b got %b",
                       $realtime, want.overlap, res_if.overlap,
                       want.plane_separated, res_if.plane_separated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sim/triangle_triangle_overlap_test_tb.sv @@
// Stimulus and verdict for the triangle pair overlap block.
`timescale 1ns / 1ps
`default_nettype none
module triangle_triangle_overlap_test_tb;
  localparam int LATENCY = ttot_pkg::NUM_STAGES + 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, expected_left, results_seen, overlap_seen, separated_seen;
  int   pairs_sent;

  ttot_in_if  pair_if ();
  ttot_out_if res_if ();
  ttot_cfg_if cfg_if ();

  triangle_triangle_overlap_test DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if.sink),
    .out_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  triangle_overlap_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pair_if        (pair_if.sink),
    .res_if         (res_if.sink),
    .cfg_if         (cfg_if.sink),
    .fail_count     (fail_count),
    .expected_left  (expected_left),
    .results_seen   (results_seen),
    .overlap_seen   (overlap_seen),
    .separated_seen (separated_seen)
  );

  always #5 clk_i = ~clk_i;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls: mostly none, occasional long ones.
  initial begin
    int g;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      g = gap_length();
      if (g > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  function automatic logic [ttot_pkg::VERTEX_W-1:0] pack_point(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // Small coordinates make touching and coplanar cases likely.
  function automatic logic [ttot_pkg::VERTEX_W-1:0] rand_point(int spread);
    return pack_point($urandom_range(0, 2*spread) - spread,
                      $urandom_range(0, 2*spread) - spread,
                      $urandom_range(0, 2*spread) - spread);
  endfunction

  task automatic send_pair(logic [ttot_pkg::VERTEX_W-1:0] a0, a1, a2, b0, b1, b2);
    pair_if.valid     <= 1'b1;
    pair_if.a_vertex0 <= a0; pair_if.a_vertex1 <= a1; pair_if.a_vertex2 <= a2;
    pair_if.b_vertex0 <= b0; pair_if.b_vertex1 <= b1; pair_if.b_vertex2 <= b2;
    @(posedge clk_i);
    while (!pair_if.ready) @(posedge clk_i);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int g);
    if (g > 0) begin
      pair_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    pair_if.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic set_tolerance(logic [ttot_pkg::TOL_W-1:0] tol);
    cfg_if.valid     <= 1'b1;
    cfg_if.tolerance <= tol;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_pair();
    int kind, s;
    logic [ttot_pkg::VERTEX_W-1:0] v [6];
    kind = $urandom_range(0, 9);
    s = (kind < 6) ? $urandom_range(1, 20) : 32767;
    for (int k = 0; k < 6; k++)
      v[k] = (kind == 9) ? ttot_pkg::VERTEX_W'({$urandom, $urandom}) : rand_point(s);
    // Shared or coplanar vertices to hit the zero orientation path.
    if (kind == 4) begin v[3] = v[0]; v[4] = v[1]; end
    if (kind == 5) for (int k = 0; k < 6; k++) v[k][47:32] = 16'(s);
    send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic directed_pairs();
    logic [ttot_pkg::VERTEX_W-1:0] o, ex, ey;
    o  = pack_point(0, 0, 0);
    ex = pack_point(10, 0, 0);
    ey = pack_point(0, 10, 0);
    send_pair(o, ex, ey, o, ex, ey);
    send_pair(pack_point(0, 0, 5), pack_point(10, 0, 5), pack_point(0, 10, 5), o, ex, ey);
    send_pair(pack_point(1, 1, -3), pack_point(2, 1, 4), pack_point(1, 2, 4), o, ex, ey);
    send_pair(o, o, o, o, ex, ey);
    send_pair(o, ex, ey, o, o, o);
    send_pair('1, '1, '1, '0, '0, '0);
    send_pair(pack_point(32767, 32767, 32767), pack_point(-32768, -32768, -32768),
              pack_point(32767, -32768, 0), pack_point(-32768, 32767, 32767),
              pack_point(0, 32767, -32768), pack_point(32767, 0, -32768));
    send_pair(pack_point(-32768, 0, 0), pack_point(0, -32768, 0), pack_point(0, 0, -32768),
              pack_point(32767, 0, 0), pack_point(0, 32767, 0), pack_point(0, 0, 32767));
    send_pair({48{1'b1}}, {48{1'b0}}, {24{2'b10}}, {24{2'b01}}, {12{4'hA}}, {12{4'h5}});
    send_pair(pack_point(5, 5, 0), pack_point(20, 5, 0), pack_point(5, 20, 0), o, ex, ey);
  endtask

  initial begin
    pairs_sent = 0;
    pair_if.valid = 1'b0;
    pair_if.a_vertex0 = '0; pair_if.a_vertex1 = '0; pair_if.a_vertex2 = '0;
    pair_if.b_vertex0 = '0; pair_if.b_vertex1 = '0; pair_if.b_vertex2 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.tolerance = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_pairs();
    drain_pipeline();
    set_tolerance(20'd1);
    directed_pairs();
    drain_pipeline();
    set_tolerance('1);
    directed_pairs();

    for (int phase = 0; phase < 5; phase++) begin
      drain_pipeline();
      case (phase)
        0: set_tolerance('0);
        1: set_tolerance(ttot_pkg::TOL_W'($urandom_range(1, 50)));
        2: set_tolerance('1);
        3: set_tolerance(ttot_pkg::TOL_W'($urandom));
        default: set_tolerance(20'd1);
      endcase
      for (int n = 0; n < 120; n++) begin
        random_pair();
        pause_sender(gap_length());
      end
    end
    drain_pipeline();
    $display("covered %0d pairs over several tolerances with receiver stalls",
             pairs_sent);
    $display("results %0d, overlaps %0d, separated %0d",
             results_seen, overlap_seen, separated_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout after %0d pairs", pairs_sent);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
